// ===== rtl/wgw_pkg.sv =====
// Shared types and constants for the greedy word wrap block.
package wgw_pkg;

    localparam int POS_BITS   = 16;
    localparam int COUNT_BITS = 24;
    localparam int LEN_BITS   = 11;
    localparam int COL_BITS   = 10;
    localparam int Q_DEPTH    = 4;
    localparam int Q_PTR_BITS = $clog2(Q_DEPTH);
    localparam int Q_CNT_BITS = $clog2(Q_DEPTH + 1);

    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_HYPHEN = 8'h2D;

    localparam logic [COL_BITS-1:0] COLUMNS_RESET = 10'd80;

    typedef struct packed {
        logic [LEN_BITS-1:0]   length;
        logic [POS_BITS-1:0]   start_offset;
        logic [COUNT_BITS-1:0] display_index;
        logic [COUNT_BITS-1:0] source_line;
    } chunk_desc_t;

    typedef struct packed {
        logic        two;
        chunk_desc_t second;
        chunk_desc_t first;
    } chunk_pair_t;

endpackage

// ===== rtl/wgw_front.sv =====
// Front end: accepts characters, tracks break marks and forms chunk descriptors.
module wgw_front
    import wgw_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic [COL_BITS-1:0] cfg_wr_data,
    input  logic                accept,
    input  logic [7:0]          ch,
    input  logic                has_char,
    input  logic                line_end,
    input  logic                restart,
    output logic                push,
    output chunk_pair_t         push_pair
);

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    function automatic logic [COL_BITS-1:0] wrap_width(input logic [COL_BITS-1:0] cols);
        logic [COL_BITS:0]   twice_cols;
        logic [23:0]         prod;
        logic [6:0]          margin;
        logic [7:0]          margins;
        logic [COL_BITS-1:0] w;
        twice_cols = {cols, 1'b0};
        // floor(2c/25) through a reciprocal multiply
        prod    = 24'(twice_cols) * 24'd5243;
        margin  = prod[23:17];
        margins = {margin, 1'b0};
        if ({2'b00, cols} <= {2'b00, margins}) begin
            w = COL_BITS'(1);
        end else begin
            w = cols - COL_BITS'(margins);
        end
        return w;
    endfunction

    function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
        return (v == COUNT_MAX) ? v : v + COUNT_BITS'(1);
    endfunction

    logic [COL_BITS-1:0]   width_reg,  width_next;
    logic [POS_BITS-1:0]   pos_reg,    pos_next;
    logic [POS_BITS-1:0]   cs_reg,     cs_next;
    logic [POS_BITS-1:0]   mpos_reg,   mpos_next;
    logic                  mvalid_reg, mvalid_next;
    logic                  mhyph_reg,  mhyph_next;
    logic                  first_reg,  first_next;
    logic [COUNT_BITS-1:0] line_reg,   line_next;
    logic [COUNT_BITS-1:0] disp_reg,   disp_next;

    logic [POS_BITS-1:0]   b_pos, b_cs, b_mpos, rel, cs1, pos1, rem, len_a;
    logic                  b_mvalid, b_mhyph, b_first, mv1, mh1, first1, is_mark;
    logic [POS_BITS-1:0]   mp1;
    logic [COUNT_BITS-1:0] b_line, b_disp, line_inc, disp1;
    logic                  brk, emit_b;
    chunk_desc_t           desc_a, desc_b;

    always_comb begin
        if (restart) begin
            b_pos    = '0;
            b_cs     = '0;
            b_mpos   = '0;
            b_mvalid = 1'b0;
            b_mhyph  = 1'b0;
            b_first  = 1'b1;
            b_line   = '0;
            b_disp   = '0;
        end else begin
            b_pos    = pos_reg;
            b_cs     = cs_reg;
            b_mpos   = mpos_reg;
            b_mvalid = mvalid_reg;
            b_mhyph  = mhyph_reg;
            b_first  = first_reg;
            b_line   = line_reg;
            b_disp   = disp_reg;
        end

        line_inc = sat_inc(b_line);
        is_mark  = (ch == CH_SPACE) || (ch == CH_HYPHEN);
        rel      = b_pos - b_cs;

        mv1 = b_mvalid;
        mp1 = b_mpos;
        mh1 = b_mhyph;
        if (has_char && is_mark && (rel != '0)) begin
            mv1 = 1'b1;
            mp1 = b_pos;
            mh1 = (ch == CH_HYPHEN);
        end

        brk = has_char && (rel >= POS_BITS'(width_reg));
        if (mv1) begin
            len_a = (mp1 - b_cs) + POS_BITS'(mh1);
        end else begin
            len_a = POS_BITS'(width_reg);
        end

        desc_a.source_line   = b_first ? line_inc : '0;
        desc_a.display_index = b_disp;
        desc_a.start_offset  = b_cs;
        desc_a.length        = len_a[LEN_BITS-1:0];

        cs1    = b_cs;
        first1 = b_first;
        disp1  = b_disp;
        if (brk) begin
            cs1    = mv1 ? mp1 + POS_BITS'(1) : b_cs + POS_BITS'(width_reg);
            mv1    = 1'b0;
            mp1    = '0;
            mh1    = 1'b0;
            first1 = 1'b0;
            disp1  = sat_inc(b_disp);
        end
        pos1 = has_char ? b_pos + POS_BITS'(1) : b_pos;

        rem    = pos1 - cs1;
        emit_b = line_end && ((rem != '0) || first1);

        desc_b.source_line   = first1 ? line_inc : '0;
        desc_b.display_index = disp1;
        desc_b.start_offset  = cs1;
        desc_b.length        = rem[LEN_BITS-1:0];

        push_pair.two    = brk && emit_b;
        push_pair.first  = brk ? desc_a : desc_b;
        push_pair.second = desc_b;
        push             = accept && (brk || emit_b);

        disp_next = emit_b ? sat_inc(disp1) : disp1;
        if (line_end) begin
            pos_next    = '0;
            cs_next     = '0;
            mpos_next   = '0;
            mvalid_next = 1'b0;
            mhyph_next  = 1'b0;
            first_next  = 1'b1;
            line_next   = line_inc;
        end else begin
            pos_next    = pos1;
            cs_next     = cs1;
            mpos_next   = mp1;
            mvalid_next = mv1;
            mhyph_next  = mh1;
            first_next  = first1;
            line_next   = b_line;
        end

        width_next = cfg_wr_en ? wrap_width(cfg_wr_data) : width_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= wrap_width(COLUMNS_RESET);
            pos_reg    <= '0;
            cs_reg     <= '0;
            mpos_reg   <= '0;
            mvalid_reg <= 1'b0;
            mhyph_reg  <= 1'b0;
            first_reg  <= 1'b1;
            line_reg   <= '0;
            disp_reg   <= '0;
        end else begin
            width_reg <= width_next;
            if (accept) begin
                pos_reg    <= pos_next;
                cs_reg     <= cs_next;
                mpos_reg   <= mpos_next;
                mvalid_reg <= mvalid_next;
                mhyph_reg  <= mhyph_next;
                first_reg  <= first_next;
                line_reg   <= line_next;
                disp_reg   <= disp_next;
            end
        end
    end

    a_width_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        width_reg != '0)
        else $error("wrap width is zero");

    a_line_end_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && line_end |=> first_reg && !mvalid_reg && (pos_reg == '0))
        else $error("line state not cleared after line end");

endmodule

// ===== rtl/wgw_queue.sv =====
// Short queue of descriptor pairs between the front and back ends.
module wgw_queue
    import wgw_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        push,
    input  chunk_pair_t push_pair,
    input  logic        pop,
    output logic        not_full,
    output logic        not_empty,
    output chunk_pair_t head_pair
);

    chunk_pair_t           mem [Q_DEPTH];
    logic [Q_PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [Q_CNT_BITS-1:0] count_reg,  count_next;

    assign not_full  = (count_reg != Q_CNT_BITS'(Q_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head_pair = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + Q_PTR_BITS'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + Q_PTR_BITS'(1) : rd_ptr_reg;
        count_next  = count_reg + Q_CNT_BITS'(push) - Q_CNT_BITS'(pop);
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_pair;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> not_full)
        else $error("queue overflow");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> not_empty)
        else $error("queue underflow");

endmodule

// ===== rtl/wgw_back.sv =====
// Back end: output register that sends each descriptor pair as one or two words.
module wgw_back
    import wgw_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        q_not_empty,
    input  chunk_pair_t q_head,
    output logic        q_pop,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,
    output logic        m_tlast
);

    logic        valid_reg,  valid_next;
    logic        second_reg, second_next;
    chunk_pair_t pair_reg;
    chunk_desc_t cur;
    logic        done;

    always_comb begin
        cur      = second_reg ? pair_reg.second : pair_reg.first;
        m_tvalid = valid_reg;
        m_tlast  = second_reg || !pair_reg.two;
        m_tdata  = {5'd0, cur.length, cur.start_offset, cur.display_index, cur.source_line};

        done  = valid_reg && m_tready && m_tlast;
        q_pop = q_not_empty && (!valid_reg || done);

        valid_next  = valid_reg;
        second_next = second_reg;
        if (q_pop) begin
            valid_next  = 1'b1;
            second_next = 1'b0;
        end else if (done) begin
            valid_next  = 1'b0;
            second_next = 1'b0;
        end else if (valid_reg && m_tready) begin
            second_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            pair_reg <= q_head;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg  <= 1'b0;
            second_reg <= 1'b0;
        end else begin
            valid_reg  <= valid_next;
            second_reg <= second_next;
        end
    end

    a_second_needs_pair: assert property (@(posedge aclk) disable iff (!aresetn)
        second_reg |-> valid_reg && pair_reg.two)
        else $error("second word without a two-word pair");

    a_advance_to_second: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg && m_tready && !m_tlast |=> valid_reg && second_reg)
        else $error("second word not presented");

endmodule

// ===== rtl/greedy_word_wrap.sv =====
// Top level of the greedy word wrap block: front end, queue and output stage.
// Each input word is one character (or an empty-line marker); the line state
// updates in the cycle that accepts it, so characters stream at one word per
// cycle while the queue has room. A character that both breaks a chunk and ends
// the line yields two descriptors, which the single output register sends as two
// words, one after the other. A four-entry queue lets input keep flowing while
// the output is stalled. A descriptor is written into the queue when its
// character is accepted and then loaded into the output register, which drives
// m_tvalid. A screen_columns write is taken at once and the new wrap width
// applies from the next accepted word.
module greedy_word_wrap
    import wgw_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic [COL_BITS-1:0] cfg_wr_data,  // screen_columns
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [7:0]          s_tdata,      // ch
    input  logic                s_tlast,      // line_end
    input  logic [1:0]          s_tuser,      // has_char, restart
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [79:0]         m_tdata,      // source_line, display_index, start_offset, length
    output logic                m_tlast       // last
);

    logic        accept;
    logic        push, pop, not_full, not_empty;
    chunk_pair_t push_pair, head_pair;

    assign s_tready = not_full;
    assign accept   = s_tvalid && s_tready;

    wgw_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .accept      (accept),
        .ch          (s_tdata),
        .has_char    (s_tuser[0]),
        .line_end    (s_tlast),
        .restart     (s_tuser[1]),
        .push        (push),
        .push_pair   (push_pair)
    );

    wgw_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_pair (push_pair),
        .pop       (pop),
        .not_full  (not_full),
        .not_empty (not_empty),
        .head_pair (head_pair)
    );

    wgw_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_not_empty (not_empty),
        .q_head      (head_pair),
        .q_pop       (pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast)
    );

endmodule
